// ----- sv/dfrf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and microprogram of the distance field restraint block.
package dfrf_pkg;

	localparam int MAX_X = 32;
	localparam int MAX_Y = 32;
	localparam int MAX_Z = 32;
	localparam int GRID_DEPTH = MAX_X * MAX_Y * MAX_Z;
	localparam int GADDR_W = $clog2(GRID_DEPTH);
	localparam int NPTS_W = 6;
	localparam int CI_W = 5;
	localparam int FRAC_W = 16;
	localparam int CFG_W = 40;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_PX = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PZ = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_K = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RL = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INV = 3'd6;

	localparam logic ITEM_WRITE = 1'b0;
	localparam logic ITEM_QUERY = 1'b1;

	localparam int LOAD_N = 32;
	localparam int LOAD_W = $clog2(LOAD_N);
	localparam int SLOT_W = 6;
	localparam int SCR_DEPTH = 2 ** SLOT_W;

	// scratch slots
	localparam int S_DIST = 0;
	localparam int S_DEV = 1;
	localparam int S_KR = 2;
	localparam int S_KD = 3;
	localparam int S_EOP = 4;
	localparam int S_FAC = 5;
	localparam int S_EN = 6;
	localparam int S_FX = 7;
	localparam int S_DX = 32;

	localparam logic [2:0] SEL_X = 3'd0;
	localparam logic [2:0] SEL_Y = 3'd1;
	localparam logic [2:0] SEL_Z = 3'd2;
	localparam logic [2:0] OUT_DIST = 3'd0;
	localparam logic [2:0] OUT_EN = 3'd1;
	localparam logic [2:0] OUT_FX = 3'd2;
	localparam logic [2:0] OUT_FY = 3'd3;
	localparam logic [2:0] OUT_FZ = 3'd4;

	typedef enum logic [3:0] {
		MOP_SUB, MOP_LERP, MOP_GRAD, MOP_DEV, MOP_KR, MOP_KD,
		MOP_BRANCH, MOP_FAC, MOP_ENERGY, MOP_FORCE, MOP_OUT
	} mop_e;

	typedef struct packed {
		mop_e op;
		logic [SLOT_W-1:0] dst;
		logic [SLOT_W-1:0] sa;
		logic [SLOT_W-1:0] sb;
		logic [2:0] sel;
	} instr_t;

	localparam int PROG_LEN = 69;
	localparam int PC_W = $clog2(PROG_LEN);
	typedef instr_t [PROG_LEN-1:0] prog_t;

	typedef struct packed {
		logic op;
		logic [14:0] cell_index;
		logic signed [31:0] cell_value;
		logic [20:0] coord_x;
		logic [20:0] coord_y;
		logic [20:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interp_dist;
		logic signed [39:0] energy;
		logic signed [39:0] force_x;
		logic signed [39:0] force_y;
		logic signed [39:0] force_z;
		logic range_error;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic clear_out;
		logic load;
		logic [LOAD_W-1:0] load_k;
		logic read;
		logic exec;
		logic wb;
		instr_t instr;
	} cmd_t;

	typedef struct packed {
		logic range_err;
		logic mul_done;
	} stat_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic sh17;
		logic sat40;
		logic negflip;
	} mul_req_t;

	function automatic logic is_mul(mop_e op);
		return (op == MOP_LERP) || (op == MOP_GRAD) || (op == MOP_KR) || (op == MOP_KD) ||
			(op == MOP_ENERGY) || (op == MOP_FORCE);
	endfunction

	function automatic instr_t mk(mop_e op, int dst, int sa, int sb, logic [2:0] sel);
		instr_t i;
		i.op = op;
		i.dst = SLOT_W'(dst);
		i.sa = SLOT_W'(sa);
		i.sb = SLOT_W'(sb);
		i.sel = sel;
		return i;
	endfunction

	function automatic prog_t build_prog();
		prog_t p;
		int pc;
		int s;
		int a;
		int b;
		int c;
		int t;
		int base;
		p = '0;
		pc = 0;
		// central differences, grid words sit in slots 0..31
		for (s = 0; s < 8; s++) begin
			a = s & 1;
			b = (s >> 1) & 1;
			c = s >> 2;
			p[pc] = mk(MOP_SUB, S_DX + s, (a != 0) ? 8 + (c * 2 + b) * 2 + 1 : s + 1,
				(a != 0) ? s - 1 : 8 + (c * 2 + b) * 2, SEL_X);
			pc++;
			p[pc] = mk(MOP_SUB, S_DX + 8 + s, (b != 0) ? 16 + (c * 2 + a) * 2 + 1 : s + 2,
				(b != 0) ? s - 2 : 16 + (c * 2 + a) * 2, SEL_X);
			pc++;
			p[pc] = mk(MOP_SUB, S_DX + 16 + s, (c != 0) ? 24 + (b * 2 + a) * 2 + 1 : s + 4,
				(c != 0) ? s - 4 : 24 + (b * 2 + a) * 2, SEL_X);
			pc++;
		end
		// trilinear passes: distance, then the three difference sets
		for (t = 0; t < 4; t++) begin
			base = (t == 0) ? S_DIST : S_DX + 8 * (t - 1);
			for (s = 0; s < 8; s += 2) begin
				p[pc] = mk(MOP_LERP, base + s, base + s, base + s + 1, SEL_X);
				pc++;
			end
			p[pc] = mk(MOP_LERP, base, base, base + 2, SEL_Y);
			pc++;
			p[pc] = mk(MOP_LERP, base + 4, base + 4, base + 6, SEL_Y);
			pc++;
			p[pc] = mk(MOP_LERP, base, base, base + 4, SEL_Z);
			pc++;
		end
		for (t = 0; t < 3; t++) begin
			p[pc] = mk(MOP_GRAD, S_DX + 8 * t, S_DX + 8 * t, 0, SEL_X);
			pc++;
		end
		p[pc] = mk(MOP_DEV, S_DEV, S_DIST, 0, SEL_X);
		pc++;
		p[pc] = mk(MOP_KR, S_KR, 0, 0, SEL_X);
		pc++;
		p[pc] = mk(MOP_KD, S_KD, S_DEV, 0, SEL_X);
		pc++;
		p[pc] = mk(MOP_BRANCH, S_EOP, S_DEV, 0, SEL_X);
		pc++;
		p[pc] = mk(MOP_FAC, S_FAC, S_KD, S_KR, SEL_X);
		pc++;
		p[pc] = mk(MOP_ENERGY, S_EN, S_FAC, S_EOP, SEL_X);
		pc++;
		for (t = 0; t < 3; t++) begin
			p[pc] = mk(MOP_FORCE, S_FX + t, S_FAC, S_DX + 8 * t, SEL_X);
			pc++;
		end
		p[pc] = mk(MOP_OUT, 0, S_DIST, 0, OUT_DIST);
		pc++;
		p[pc] = mk(MOP_OUT, 0, S_EN, 0, OUT_EN);
		pc++;
		p[pc] = mk(MOP_OUT, 0, S_FX, 0, OUT_FX);
		pc++;
		p[pc] = mk(MOP_OUT, 0, S_FX + 1, 0, OUT_FY);
		pc++;
		p[pc] = mk(MOP_OUT, 0, S_FX + 2, 0, OUT_FZ);
		return p;
	endfunction

endpackage

// ----- sv/dfrf_mul.sv -----
`timescale 1ns / 1ps
// Multi-cycle signed multiply with rounding shift and magnitude saturation.
module dfrf_mul (
	input logic clk,
	input logic arst_n,
	input dfrf_pkg::mul_req_t req,
	output logic done,
	output logic signed [63:0] prod
);
	import dfrf_pkg::*;

	localparam logic [2:0] CNT_RND = 3'd4;
	localparam logic [2:0] CNT_FIN = 3'd5;
	localparam logic [63:0] BIGLIM = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SAT40 = 64'h0000_007F_FFFF_FFFF;

	logic [63:0] ua_q, ub_q, absa, absb;
	logic neg_q, sh17_q, sat_q, run_q, done_q;
	logic [2:0] cnt_q;
	logic [127:0] acc_q, pps, rs;
	logic [63:0] pp, lim, mag;
	logic signed [63:0] res_q;

	assign absa = req.a[63] ? 64'(-req.a) : 64'(req.a);
	assign absb = req.b[63] ? 64'(-req.b) : 64'(req.b);

	always_comb begin
		pp = (cnt_q[0] ? ua_q[63:32] : ua_q[31:0]) * (cnt_q[1] ? ub_q[63:32] : ub_q[31:0]);
		case (cnt_q[1:0])
			2'd0: pps = {64'd0, pp};
			2'd3: pps = {pp, 64'd0};
			default: pps = {32'd0, pp, 32'd0};
		endcase
		rs = sh17_q ? (acc_q >> 17) : (acc_q >> 16);
		lim = sat_q ? SAT40 : BIGLIM;
		mag = ((rs[127:64] != 64'd0) || (rs[63:0] > lim)) ? lim : rs[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == CNT_FIN) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q <= absa;
			ub_q <= absb;
			neg_q <= req.a[63] ^ req.b[63] ^ req.negflip;
			sh17_q <= req.sh17;
			sat_q <= req.sat40;
			acc_q <= '0;
		end else if (run_q) begin
			if (cnt_q < CNT_RND) begin
				acc_q <= acc_q + pps;
			end else if (cnt_q == CNT_RND) begin
				acc_q <= acc_q + (sh17_q ? (128'd1 << 16) : (128'd1 << 15));
			end else begin
				res_q <= neg_q ? -$signed(mag) : $signed(mag);
			end
		end
	end

	assign done = done_q;
	assign prod = res_q;
endmodule

// ----- sv/dfrf_dp.sv -----
`timescale 1ns / 1ps
// Datapath: grid store, scratch memory, operand handling and result register.
module dfrf_dp (
	input logic clk,
	input logic arst_n,
	input dfrf_pkg::cmd_t cmd,
	output dfrf_pkg::stat_t stat,
	input dfrf_pkg::in_item_t item,
	input logic cfg_we,
	input logic [dfrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dfrf_pkg::CFG_W-1:0] cfg_data,
	output dfrf_pkg::mul_req_t mreq,
	input logic mul_done,
	input logic signed [63:0] mres,
	output dfrf_pkg::out_item_t result
);
	import dfrf_pkg::*;

	typedef enum logic [1:0] {BR_HARM, BR_LOWER, BR_UPPER} br_e;

	logic [NPTS_W-1:0] px_q, py_q, pz_q, nx, ny, nz;
	logic [39:0] k_q;
	logic [30:0] ref_q, rl_q;
	logic [31:0] inv_q;
	logic [CI_W-1:0] ipx_q, ipy_q, ipz_q;
	logic [FRAC_W-1:0] wx_q, wy_q, wz_q;
	logic rerr_q;
	logic [31:0] gmem [GRID_DEPTH];
	logic [31:0] g_rd_q;
	logic [GADDR_W-1:0] gaddr;
	logic ld_vld_s1;
	logic [SLOT_W-1:0] ld_slot_s1;
	logic [63:0] smem [SCR_DEPTH];
	logic signed [63:0] ra_q, rb_q, alu_q, wv, swd, dev, rlx, ee;
	logic [SLOT_W-1:0] swa;
	logic swe;
	br_e br_q;
	out_item_t out_q;
	logic [5:0] offs;
	logic [CI_W-1:0] xi, yi, zi;
	logic [15:0] yz, lin;
	logic [FRAC_W-1:0] wsel;
	logic is_lo, is_hi;
	instr_t ins;

	assign ins = cmd.instr;

	function automatic logic [NPTS_W-1:0] clampn(logic [NPTS_W-1:0] v, logic [NPTS_W-1:0] mx);
		if (v < NPTS_W'(2)) return NPTS_W'(2);
		return (v > mx) ? mx : v;
	endfunction

	// wrapped neighbor index: offset 0 is one below, 1 the cell, 2 and 3 above
	function automatic logic [CI_W-1:0] wrap_idx(logic [CI_W-1:0] ip, logic [NPTS_W-1:0] n,
		logic [1:0] o);
		logic [NPTS_W:0] t;
		t = '0;
		case (o)
			2'd0: t = (ip == '0) ? (NPTS_W+1)'(n) - 1'b1 : (NPTS_W+1)'(ip) - 1'b1;
			2'd1: t = (NPTS_W+1)'(ip);
			2'd2: t = ((NPTS_W+1)'(ip) + 1'b1 == (NPTS_W+1)'(n)) ? '0 :
				(NPTS_W+1)'(ip) + 1'b1;
			default: begin
				t = (NPTS_W+1)'(ip) + (NPTS_W+1)'(2);
				if (t >= (NPTS_W+1)'(n)) t = t - (NPTS_W+1)'(n);
			end
		endcase
		return t[CI_W-1:0];
	endfunction

	// point k of the load order: {oz, oy, ox}, centers first, then x, y, z extras
	function automatic logic [5:0] load_off(logic [LOAD_W-1:0] k);
		logic [1:0] e, lo, hi;
		e = k[0] ? 2'd3 : 2'd0;
		lo = {1'b0, k[1]} + 2'd1;
		hi = {1'b0, k[2]} + 2'd1;
		case (k[4:3])
			2'd0: return {hi, lo, {1'b0, k[0]} + 2'd1};
			2'd1: return {hi, lo, e};
			2'd2: return {hi, e, lo};
			default: return {e, hi, lo};
		endcase
	endfunction

	assign nx = clampn(px_q, NPTS_W'(MAX_X));
	assign ny = clampn(py_q, NPTS_W'(MAX_Y));
	assign nz = clampn(pz_q, NPTS_W'(MAX_Z));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= NPTS_W'(32);
			py_q <= NPTS_W'(32);
			pz_q <= NPTS_W'(32);
			k_q <= '0;
			ref_q <= '0;
			rl_q <= '0;
			inv_q <= 32'd327680;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PX: px_q <= cfg_data[NPTS_W-1:0];
				REG_PY: py_q <= cfg_data[NPTS_W-1:0];
				REG_PZ: pz_q <= cfg_data[NPTS_W-1:0];
				REG_K: k_q <= cfg_data;
				REG_REF: ref_q <= cfg_data[30:0];
				REG_RL: rl_q <= cfg_data[30:0];
				REG_INV: inv_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rerr_q <= 1'b0;
			ld_vld_s1 <= 1'b0;
		end else begin
			ld_vld_s1 <= cmd.load;
			if (cmd.accept && item.op == ITEM_QUERY)
				rerr_q <= ({1'b0, item.coord_x[20:16]} >= nx) ||
					({1'b0, item.coord_y[20:16]} >= ny) ||
					({1'b0, item.coord_z[20:16]} >= nz);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.op == ITEM_QUERY) begin
			ipx_q <= item.coord_x[20:16];
			ipy_q <= item.coord_y[20:16];
			ipz_q <= item.coord_z[20:16];
			wx_q <= item.coord_x[15:0];
			wy_q <= item.coord_y[15:0];
			wz_q <= item.coord_z[15:0];
		end
	end

	// grid address of the point being loaded
	always_comb begin
		offs = load_off(cmd.load_k);
		xi = wrap_idx(ipx_q, nx, offs[1:0]);
		yi = wrap_idx(ipy_q, ny, offs[3:2]);
		zi = wrap_idx(ipz_q, nz, offs[5:4]);
		yz = 16'(yi) + 16'(ny) * 16'(zi);
		lin = 16'(xi) + 16'(nx) * yz;
		gaddr = lin[GADDR_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && item.op == ITEM_WRITE)
			gmem[item.cell_index] <= item.cell_value;
		g_rd_q <= gmem[gaddr];
		ld_slot_s1 <= SLOT_W'(cmd.load_k);
	end

	always_comb begin
		case (ins.sel)
			SEL_X: wsel = wx_q;
			SEL_Y: wsel = wy_q;
			default: wsel = wz_q;
		endcase
		rlx = 64'(rl_q);
		dev = ra_q;
		is_lo = dev <= -rlx;
		is_hi = dev >= rlx;
		if (is_lo) ee = -((dev <<< 1) + rlx);
		else if (is_hi) ee = (dev <<< 1) - rlx;
		else ee = dev;
	end

	always_comb begin
		mreq = '0;
		mreq.start = cmd.exec && is_mul(ins.op);
		case (ins.op)
			MOP_LERP: begin
				mreq.a = rb_q - ra_q;
				mreq.b = 64'(wsel);
			end
			MOP_GRAD: begin
				mreq.a = ra_q;
				mreq.b = 64'(inv_q);
			end
			MOP_KR: begin
				mreq.a = 64'(k_q);
				mreq.b = rlx;
			end
			MOP_KD: begin
				mreq.a = 64'(k_q);
				mreq.b = ra_q;
			end
			MOP_ENERGY: begin
				mreq.a = ra_q;
				mreq.b = rb_q;
				mreq.sh17 = 1'b1;
				mreq.sat40 = 1'b1;
			end
			MOP_FORCE: begin
				mreq.a = ra_q;
				mreq.b = rb_q;
				mreq.sat40 = 1'b1;
				mreq.negflip = (br_q != BR_LOWER);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.read) begin
			ra_q <= smem[ins.sa];
			rb_q <= smem[ins.sb];
		end
		if (cmd.exec) begin
			case (ins.op)
				MOP_SUB: alu_q <= ra_q - rb_q;
				MOP_DEV: alu_q <= ra_q - 64'(ref_q);
				MOP_BRANCH: begin
					alu_q <= ee;
					br_q <= is_lo ? BR_LOWER : (is_hi ? BR_UPPER : BR_HARM);
				end
				MOP_FAC: alu_q <= (br_q == BR_HARM) ? ra_q : rb_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ins.op)
			MOP_LERP: wv = ra_q + mres;
			MOP_GRAD, MOP_KR, MOP_KD, MOP_ENERGY, MOP_FORCE: wv = mres;
			default: wv = alu_q;
		endcase
		swe = ld_vld_s1 || (cmd.wb && ins.op != MOP_OUT);
		swa = ld_vld_s1 ? ld_slot_s1 : ins.dst;
		swd = ld_vld_s1 ? 64'($signed(g_rd_q)) : wv;
	end

	always_ff @(posedge clk) begin
		if (swe)
			smem[swa] <= swd;
	end

	always_ff @(posedge clk) begin
		if (cmd.clear_out) begin
			out_q <= '{interp_dist: '0, energy: '0, force_x: '0, force_y: '0,
				force_z: '0, range_error: rerr_q};
		end else if (cmd.wb && ins.op == MOP_OUT) begin
			case (ins.sel)
				OUT_DIST: out_q.interp_dist <= ra_q[31:0];
				OUT_EN: out_q.energy <= ra_q[39:0];
				OUT_FX: out_q.force_x <= ra_q[39:0];
				OUT_FY: out_q.force_y <= ra_q[39:0];
				default: out_q.force_z <= ra_q[39:0];
			endcase
		end
	end

	assign stat.range_err = rerr_q;
	assign stat.mul_done = mul_done;
	assign result = out_q;
endmodule

// ----- sv/dfrf_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: item sequencing, grid load order and microprogram stepping.
module dfrf_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic start_op,
	input dfrf_pkg::stat_t stat,
	output dfrf_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);
	import dfrf_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_CHECK = 9'b000000010,
		ST_LOAD = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_READ = 9'b000010000,
		ST_EXEC = 9'b000100000,
		ST_MWAIT = 9'b001000000,
		ST_WB = 9'b010000000,
		ST_DONE = 9'b100000000
	} state_t;

	localparam prog_t PROG = build_prog();

	state_t state_q, state_d;
	logic [LOAD_W-1:0] k_q;
	logic [PC_W-1:0] pc_q;
	instr_t instr;

	assign instr = PROG[pc_q];

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.instr = instr;
		cmd.load_k = k_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = start;
				if (start && start_op == ITEM_QUERY) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.clear_out = 1'b1;
				state_d = stat.range_err ? ST_DONE : ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				if (k_q == LOAD_W'(LOAD_N - 1)) state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_READ;
			ST_READ: begin
				cmd.read = 1'b1;
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d = is_mul(instr.op) ? ST_MWAIT : ST_WB;
			end
			ST_MWAIT: if (stat.mul_done) state_d = ST_WB;
			ST_WB: begin
				cmd.wb = 1'b1;
				state_d = (pc_q == PC_W'(PROG_LEN - 1)) ? ST_DONE : ST_READ;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
			pc_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				k_q <= '0;
				pc_q <= '0;
			end
			if (state_q == ST_LOAD) k_q <= k_q + 1'b1;
			if (state_q == ST_WB && pc_q != PC_W'(PROG_LEN - 1)) pc_q <= pc_q + 1'b1;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
endmodule

// ----- sv/distance_field_restraint_force.sv -----
`timescale 1ns / 1ps
// Top level of the distance field restraint block.
//
// Usage: present an item on the item port and raise start; the item transfers
// at a rising edge with start high and busy low. A write item (op 0) stores
// cell_value at cell_index in the grid store in that same cycle; busy stays low
// and no result follows. Load the grid before any query reads it.
// A query item (op 1) raises busy and, when done, shows one result on the
// result port, marked by done for exactly one cycle. The receiver cannot stall.
// A coordinate outside the grid skips the grid load and returns range_error
// with zero values. A valid query reads 32 grid words, one per cycle, then steps
// a 69-entry microprogram through a 4-pass 32x32 multiply unit: 37 multiply
// steps and 32 other steps (subtract, select and output).
// The shared multiplier paces the query; one query is in flight at a time.
// Configuration writes transfer on cfg_valid/cfg_ready (always ready) and
// must be made while busy is low.
// Reset: clears the controller and restores register defaults; the grid store
// holds no defined contents until written.
module distance_field_restraint_force (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input dfrf_pkg::in_item_t item,
	output logic done,
	output dfrf_pkg::out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [dfrf_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [dfrf_pkg::CFG_W-1:0] cfg_data
);
	import dfrf_pkg::*;

	cmd_t cmd;
	stat_t stat;
	mul_req_t mreq;
	logic mul_done;
	logic signed [63:0] mres;

	// registers are always writable; the user must only change them while the block is idle (not enforced)
	assign cfg_ready = 1'b1;

	dfrf_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.start_op(item.op),
		.stat(stat),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	dfrf_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.item(item),
		.cfg_we(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mreq(mreq),
		.mul_done(mul_done),
		.mres(mres),
		.result(result)
	);

	dfrf_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.done(mul_done),
		.prod(mres)
	);
endmodule

// ----- sv/dfrf_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for the distance field restraint block and its bind.
module dfrf_chk (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input dfrf_pkg::in_item_t item,
	input logic done,
	input dfrf_pkg::out_item_t result
);
	import dfrf_pkg::*;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == ITEM_WRITE) |=> (!busy && !done))
		else $error("write transfer left the block busy or produced a result");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.op == ITEM_QUERY) |=> busy)
		else $error("query transfer did not raise busy");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe without a query in flight");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.range_error) |-> (result.interp_dist == 0 && result.energy == 0 &&
		result.force_x == 0 && result.force_y == 0 && result.force_z == 0))
		else $error("range error result carries nonzero values");
endmodule

bind distance_field_restraint_force dfrf_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.item(item),
	.done(done),
	.result(result)
);
